// ===== hdl/ffha_pkg.sv =====
// Shared constants, codes and types of the first-fit heap allocator.
package ffha_pkg;

	localparam int unsigned HEAP_BYTES   = 1048576;
	localparam int unsigned HEADER_BYTES = 16;
	localparam int unsigned MAX_BLOCKS   = 256;
	localparam int unsigned GUARD_BYTES  = 4;
	localparam logic [31:0] BASE_RESET   = 32'h0100_0000;

	localparam int unsigned OFF_W = $clog2(HEAP_BYTES);
	localparam int unsigned IDX_W = $clog2(MAX_BLOCKS);
	localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_NOFIT    = 3'd1,
		ST_BADSIZE  = 3'd2,
		ST_NULL     = 3'd3,
		ST_RANGE    = 3'd4,
		ST_NOTBLOCK = 3'd5,
		ST_DOUBLE   = 3'd6
	} status_e;

	typedef struct packed {
		logic        command;
		logic [31:0] request_size;
		logic [31:0] address;
	} req_t;

	typedef struct packed {
		logic [31:0] data_address;
		logic [2:0]  status;
	} res_t;

	typedef struct packed {
		logic [OFF_W-1:0] off;
		logic [OFF_W-1:0] size;
		logic             free;
	} entry_t;

	typedef struct packed {
		logic    load;
		logic    rd;
		logic    idx_inc;
		logic    cap;
		logic    sh_init;
		logic    sh_rd;
		logic    sh_wr;
		logic    wr_rem;
		logic    wr_use;
		logic    wr_free;
		logic    emit;
		status_e emit_status;
	} cmd_t;

	typedef struct packed {
		logic    is_free;
		status_e pre;
		logic    hit;
		logic    last;
		logic    split;
		logic    efree;
		logic    sh_done;
	} stat_t;

endpackage

// ===== hdl/first_fit_heap_allocator.sv =====
// Top level of the first-fit heap allocator: controller and datapath.
//  channel  | signals                  | handshake
//  command  | start, busy, item        | beat taken when start & !busy
//  result   | done, result             | one-cycle strobe, no back-pressure
//  config   | cfg_valid, cfg_ready, cfg_data | beat when valid & ready
// An item takes a pre-check state, a check of each table entry walked (one
// registered memory read each) and a result issue; a split adds a read and a
// write per entry moved up, a final check and the remainder write. Reset leaves
// one free block in entry zero with no clearing pass. The done strobe is registered;
// busy is already low when it rises, and a new start may be taken in that cycle.
module first_fit_heap_allocator (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  ffha_pkg::req_t item,
	output logic           done,
	output ffha_pkg::res_t result,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [31:0]    cfg_data
);

	ffha_pkg::cmd_t  cmd;
	ffha_pkg::stat_t st;

	assign cfg_ready = 1'b1;

	ffha_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.st     (st),
		.cmd    (cmd)
	);

	ffha_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.st        (st),
		.done      (done),
		.result    (result)
	);

endmodule

// ===== hdl/ffha_ctrl.sv =====
// Sequencer of the allocator: list walk, table shift and result issue.
module ffha_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  ffha_pkg::stat_t st,
	output ffha_pkg::cmd_t  cmd
);

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_PRE   = 9'b000000010,
		S_RD    = 9'b000000100,
		S_CHK   = 9'b000001000,
		S_SHCHK = 9'b000010000,
		S_SHWR  = 9'b000100000,
		S_WREM  = 9'b001000000,
		S_WUSE  = 9'b010000000,
		S_WFREE = 9'b100000000
	} state_t;

	state_t state_q, state_d;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.emit_status = ffha_pkg::ST_OK;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d = S_PRE;
				end
			end
			S_PRE: begin
				if (st.pre != ffha_pkg::ST_OK) begin
					cmd.emit = 1'b1;
					cmd.emit_status = st.pre;
					state_d = S_IDLE;
				end else begin
					cmd.rd = 1'b1;
					state_d = S_CHK;
				end
			end
			S_RD: begin
				cmd.rd = 1'b1;
				state_d = S_CHK;
			end
			S_CHK: begin
				if (st.hit) begin
					cmd.cap = 1'b1;
					if (st.is_free) begin
						if (st.efree) begin
							cmd.emit = 1'b1;
							cmd.emit_status = ffha_pkg::ST_DOUBLE;
							state_d = S_IDLE;
						end else begin
							state_d = S_WFREE;
						end
					end else if (st.split) begin
						cmd.sh_init = 1'b1;
						state_d = S_SHCHK;
					end else begin
						state_d = S_WUSE;
					end
				end else if (st.last) begin
					cmd.emit = 1'b1;
					cmd.emit_status = st.is_free ? ffha_pkg::ST_NOTBLOCK : ffha_pkg::ST_NOFIT;
					state_d = S_IDLE;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d = S_RD;
				end
			end
			S_SHCHK: begin
				if (st.sh_done) begin
					state_d = S_WREM;
				end else begin
					cmd.sh_rd = 1'b1;
					state_d = S_SHWR;
				end
			end
			S_SHWR: begin
				cmd.sh_wr = 1'b1;
				state_d = S_SHCHK;
			end
			S_WREM: begin
				cmd.wr_rem = 1'b1;
				state_d = S_WUSE;
			end
			S_WUSE: begin
				cmd.wr_use = 1'b1;
				cmd.emit = 1'b1;
				state_d = S_IDLE;
			end
			S_WFREE: begin
				cmd.wr_free = 1'b1;
				cmd.emit = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== hdl/ffha_dp.sv =====
// Datapath of the allocator: block table memory, index registers, checks, result.
module ffha_dp (
	input  logic            clk,
	input  logic            arst_n,
	input  ffha_pkg::req_t  item,
	input  logic            cfg_valid,
	input  logic [31:0]     cfg_data,
	input  ffha_pkg::cmd_t  cmd,
	output ffha_pkg::stat_t st,
	output logic            done,
	output ffha_pkg::res_t  result
);

	localparam int unsigned OW = ffha_pkg::OFF_W;
	localparam int unsigned IW = ffha_pkg::IDX_W;
	localparam int unsigned CW = ffha_pkg::CNT_W;
	localparam logic [OW-1:0] HDR   = OW'(ffha_pkg::HEADER_BYTES);
	localparam logic [OW-1:0] GUARD = OW'(ffha_pkg::GUARD_BYTES);
	localparam logic [OW-1:0] SPLIT_MIN =
		OW'(ffha_pkg::HEADER_BYTES + ffha_pkg::GUARD_BYTES + 8);
	localparam logic [OW-1:0] SIZE_RESET =
		OW'(ffha_pkg::HEAP_BYTES - ffha_pkg::HEADER_BYTES - ffha_pkg::GUARD_BYTES);
	localparam logic [31:0] QUARTER = 32'(ffha_pkg::HEAP_BYTES / 4);
	localparam logic [32:0] HEAP33  = 33'(ffha_pkg::HEAP_BYTES);

	ffha_pkg::entry_t mem [ffha_pkg::MAX_BLOCKS];
	ffha_pkg::entry_t rd_q, e, ent_q, wdata;

	logic [31:0]      base_q;
	logic             is_free_q, zero_q, e0_init_q, split_q;
	ffha_pkg::status_e pre_q, pre_d;
	logic [OW-1:0]    need_q, rel_q, rem;
	logic [IW-1:0]    idx_q, sh_q, raddr, waddr;
	logic [CW-1:0]    slots_q;
	logic             we;
	logic [31:0]      diff;
	logic [32:0]      diff33;

	// pre-checks on the incoming beat
	always_comb begin
		diff   = item.address - base_q;
		diff33 = {1'b0, item.address} - {1'b0, base_q};
		pre_d  = ffha_pkg::ST_OK;
		if (item.command == ffha_pkg::CMD_ALLOC) begin
			if (item.request_size == 32'd0 || item.request_size > QUARTER)
				pre_d = ffha_pkg::ST_BADSIZE;
		end else if (item.address == 32'd0) begin
			pre_d = ffha_pkg::ST_NULL;
		end else if (diff33[32] || diff33 >= HEAP33) begin
			pre_d = ffha_pkg::ST_RANGE;
		end else if (diff < 32'(ffha_pkg::HEADER_BYTES)) begin
			pre_d = ffha_pkg::ST_NOTBLOCK;
		end
	end

	// entry zero holds its reset value until first written
	always_comb begin
		e = rd_q;
		if (zero_q) begin
			e.off  = '0;
			e.size = SIZE_RESET;
			e.free = 1'b1;
		end
	end

	assign rem = e.size - need_q;

	always_comb begin
		st.is_free = is_free_q;
		st.pre     = pre_q;
		st.hit     = is_free_q ? (e.off == rel_q) : (e.free && e.size >= need_q);
		st.last    = ({1'b0, idx_q} == slots_q - CW'(1));
		st.split   = (rem > SPLIT_MIN) && (slots_q != CW'(ffha_pkg::MAX_BLOCKS));
		st.efree   = e.free;
		st.sh_done = (sh_q == idx_q);
	end

	assign raddr = cmd.rd ? idx_q : sh_q;

	always_comb begin
		we = 1'b1;
		waddr = idx_q;
		wdata = ent_q;
		if (cmd.sh_wr) begin
			waddr = sh_q + IW'(1);
			wdata = e;
		end else if (cmd.wr_rem) begin
			waddr = idx_q + IW'(1);
			wdata.off  = ent_q.off + HDR + need_q + GUARD;
			wdata.size = ent_q.size - need_q - HDR - GUARD;
			wdata.free = 1'b1;
		end else if (cmd.wr_use) begin
			wdata.free = 1'b0;
			if (split_q)
				wdata.size = need_q;
		end else if (cmd.wr_free) begin
			wdata.free = 1'b1;
		end else begin
			we = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (cmd.rd || cmd.sh_rd)
			rd_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q    <= ffha_pkg::BASE_RESET;
			slots_q   <= CW'(1);
			e0_init_q <= 1'b1;
			zero_q    <= 1'b0;
			done      <= 1'b0;
			idx_q     <= '0;
			sh_q      <= '0;
		end else begin
			if (cfg_valid)
				base_q <= cfg_data;
			if (we && waddr == '0)
				e0_init_q <= 1'b0;
			if (cmd.rd || cmd.sh_rd)
				zero_q <= e0_init_q && (raddr == '0);
			if (cmd.load)
				idx_q <= '0;
			else if (cmd.idx_inc)
				idx_q <= idx_q + IW'(1);
			if (cmd.sh_init)
				sh_q <= IW'(slots_q - CW'(1));
			else if (cmd.sh_wr)
				sh_q <= sh_q - IW'(1);
			if (cmd.wr_rem)
				slots_q <= slots_q + CW'(1);
			done <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			is_free_q <= item.command;
			pre_q     <= pre_d;
			need_q    <= (item.request_size[OW-1:0] + OW'(7)) & ~OW'(7);
			rel_q     <= diff[OW-1:0] - HDR;
		end
		if (cmd.cap) begin
			ent_q   <= e;
			split_q <= st.split;
		end
		if (cmd.emit) begin
			result.status <= cmd.emit_status;
			if (!is_free_q && cmd.emit_status == ffha_pkg::ST_OK)
				result.data_address <= base_q + 32'(ent_q.off) + 32'(ffha_pkg::HEADER_BYTES);
			else
				result.data_address <= 32'd0;
		end
	end

endmodule

// ===== dv/tb_first_fit_heap_allocator.sv =====
// Self-checking testbench for the first-fit heap allocator: directed table then random traffic.
`timescale 1ns / 1ps
module tb_first_fit_heap_allocator;
	import ffha_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 3000000;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	req_t        item;
	logic        done;
	res_t        result;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [31:0] cfg_data;

	first_fit_heap_allocator u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0; #5;
		clk = 1'b1; #5;
	end

	// shadow of the block table
	logic [31:0] mdl_off  [MAX_BLOCKS];
	logic [31:0] mdl_size [MAX_BLOCKS];
	logic        mdl_free [MAX_BLOCKS];
	int unsigned mdl_used;
	logic [31:0] mdl_base;

	res_t        pending_res[$];
	logic [31:0] live_addr[$];
	int unsigned n_fail, n_beats, n_checked, cycles;
	int unsigned n_split, n_full;
	int          idle_pct;

	function automatic void heap_reset();
		for (int i = 0; i < MAX_BLOCKS; i++) begin
			mdl_off[i] = '0; mdl_size[i] = '0; mdl_free[i] = 1'b0;
		end
		mdl_size[0] = HEAP_BYTES - HEADER_BYTES - GUARD_BYTES;
		mdl_free[0] = 1'b1;
		mdl_used = 1;
		mdl_base = BASE_RESET;
	endfunction

	function automatic res_t heap_alloc(logic [31:0] req);
		res_t r;
		logic [31:0] need, rem;
		r.data_address = '0;
		if (req == 0 || req > HEAP_BYTES / 4) begin
			r.status = ST_BADSIZE;
			return r;
		end
		need = (req + 32'd7) & ~32'd7;
		for (int i = 0; i < mdl_used; i++) begin
			if (mdl_free[i] && mdl_size[i] >= need) begin
				rem = mdl_size[i] - need;
				if (rem > HEADER_BYTES + GUARD_BYTES + 8) begin
					if (mdl_used < MAX_BLOCKS) begin
						for (int j = mdl_used; j > i + 1; j--) begin
							mdl_off[j] = mdl_off[j-1];
							mdl_size[j] = mdl_size[j-1];
							mdl_free[j] = mdl_free[j-1];
						end
						mdl_off[i+1] = mdl_off[i] + HEADER_BYTES + need + GUARD_BYTES;
						mdl_size[i+1] = rem - HEADER_BYTES - GUARD_BYTES;
						mdl_free[i+1] = 1'b1;
						mdl_size[i] = need;
						mdl_used++;
						n_split++;
					end else begin
						n_full++;
					end
				end
				mdl_free[i] = 1'b0;
				r.data_address = mdl_base + mdl_off[i] + HEADER_BYTES;
				r.status = ST_OK;
				return r;
			end
		end
		r.status = ST_NOFIT;
		return r;
	endfunction

	function automatic res_t heap_free(logic [31:0] addr);
		res_t r;
		logic [32:0] lim;
		logic [31:0] rel;
		r.data_address = '0;
		lim = {1'b0, mdl_base} + HEAP_BYTES;
		if (addr == 0) r.status = ST_NULL;
		else if (addr < mdl_base || {1'b0, addr} >= lim) r.status = ST_RANGE;
		else begin
			rel = addr - mdl_base;
			r.status = ST_NOTBLOCK;
			if (rel >= HEADER_BYTES) begin
				rel -= HEADER_BYTES;
				for (int i = 0; i < mdl_used; i++) begin
					if (mdl_off[i] == rel) begin
						if (mdl_free[i]) r.status = ST_DOUBLE;
						else begin
							mdl_free[i] = 1'b1;
							r.status = ST_OK;
						end
						break;
					end
				end
			end
		end
		return r;
	endfunction

	// issue one command; predicted result queued on acceptance
	// start stays high after the beat until the next call or drain drops it
	task automatic send_cmd(logic cmd, logic [31:0] sz, logic [31:0] addr,
			bit fixed, res_t want);
		res_t r;
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
			while ($urandom_range(99) < idle_pct) @(negedge clk);
		end
		start <= 1'b1;
		item <= '{command: cmd, request_size: sz, address: addr};
		@(posedge clk);
		while (busy) @(posedge clk);
		r = (cmd == CMD_ALLOC) ? heap_alloc(sz) : heap_free(addr);
		if (r.status == ST_OK && cmd == CMD_ALLOC) live_addr.push_back(r.data_address);
		if (fixed && r != want) begin
			$error("table row disagrees with predictor: want %h got %h", want, r);
			n_fail++;
		end
		pending_res.push_back(r);
		n_beats++;
		@(negedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pending_res.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_base(logic [31:0] b);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= b;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		mdl_base = b;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// result checker
	always @(posedge clk) begin
		res_t w;
		if (arst_n && done) begin
			if (pending_res.size() == 0) begin
				$error("result beat with nothing expected: %h", result);
				n_fail++;
			end else begin
				w = pending_res.pop_front();
				n_checked++;
				if (result.data_address !== w.data_address) begin
					$error("data_address: expected %h actual %h", w.data_address,
						result.data_address);
					n_fail++;
				end
				if (result.status !== w.status) begin
					$error("status: expected %0d actual %0d", w.status, result.status);
					n_fail++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	typedef struct {
		logic        cmd;
		logic [31:0] sz;
		logic [31:0] addr;
		bit          fixed;
		res_t        want;
	} row_t;

	row_t dir_rows[$];

	function automatic row_t mk(logic c, logic [31:0] s, logic [31:0] a, bit f,
			logic [31:0] da, status_e st);
		row_t r;
		r.cmd = c; r.sz = s; r.addr = a; r.fixed = f;
		r.want.data_address = da; r.want.status = st;
		return r;
	endfunction

	task automatic random_phase(int unsigned n, int pct);
		logic [31:0] s, a;
		int unsigned k;
		idle_pct = pct;
		repeat (n) begin
			k = $urandom_range(99);
			if (k < 45) begin
				s = ($urandom_range(9) == 0) ? $urandom_range(HEAP_BYTES / 4)
					: $urandom_range(600);
				if ($urandom_range(19) == 0) s = $urandom;
				send_cmd(CMD_ALLOC, s, $urandom, 0, '0);
			end else if (k < 80 && live_addr.size() != 0) begin
				a = live_addr[$urandom_range(live_addr.size() - 1)];
				send_cmd(CMD_FREE, $urandom, a, 0, '0);
			end else begin
				case ($urandom_range(3))
					0: a = $urandom;
					1: a = mdl_base + $urandom_range(HEAP_BYTES - 1);
					2: a = 32'h0;
					default: a = mdl_base + HEAP_BYTES + $urandom_range(7);
				endcase
				send_cmd(CMD_FREE, $urandom, a, 0, '0);
			end
		end
	endtask

	initial begin
		n_fail = 0; n_beats = 0; n_checked = 0; cycles = 0;
		n_split = 0; n_full = 0; idle_pct = 0;
		arst_n = 1'b0; start = 1'b0; item = '0; cfg_valid = 1'b0; cfg_data = '0;
		heap_reset();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		dir_rows.push_back(mk(CMD_ALLOC, 32'd0, 0, 1, 0, ST_BADSIZE));
		dir_rows.push_back(mk(CMD_ALLOC, HEAP_BYTES / 4 + 1, 0, 1, 0, ST_BADSIZE));
		dir_rows.push_back(mk(CMD_ALLOC, 32'hFFFF_FFFF, 0, 1, 0, ST_BADSIZE));
		dir_rows.push_back(mk(CMD_ALLOC, 32'd1, 0, 1, BASE_RESET + HEADER_BYTES, ST_OK));
		dir_rows.push_back(mk(CMD_ALLOC, HEAP_BYTES / 4, 0, 0, 0, ST_OK));
		dir_rows.push_back(mk(CMD_ALLOC, HEAP_BYTES / 4, 0, 0, 0, ST_OK));
		dir_rows.push_back(mk(CMD_ALLOC, HEAP_BYTES / 4, 0, 0, 0, ST_OK));
		dir_rows.push_back(mk(CMD_ALLOC, HEAP_BYTES / 4, 0, 1, 0, ST_NOFIT));
		dir_rows.push_back(mk(CMD_FREE, 32'hFFFF_FFFF, 0, 1, 0, ST_NULL));
		dir_rows.push_back(mk(CMD_FREE, 0, BASE_RESET - 1, 1, 0, ST_RANGE));
		dir_rows.push_back(mk(CMD_FREE, 0, BASE_RESET + HEAP_BYTES, 1, 0, ST_RANGE));
		dir_rows.push_back(mk(CMD_FREE, 0, 32'hFFFF_FFFF, 1, 0, ST_RANGE));
		dir_rows.push_back(mk(CMD_FREE, 0, BASE_RESET, 1, 0, ST_NOTBLOCK));
		dir_rows.push_back(mk(CMD_FREE, 0, BASE_RESET + 20, 1, 0, ST_NOTBLOCK));
		dir_rows.push_back(mk(CMD_FREE, 0, BASE_RESET + HEADER_BYTES, 1, 0, ST_OK));
		dir_rows.push_back(mk(CMD_FREE, 0, BASE_RESET + HEADER_BYTES, 1, 0, ST_DOUBLE));
		dir_rows.push_back(mk(CMD_ALLOC, 32'd8, 0, 1, BASE_RESET + HEADER_BYTES, ST_OK));
		dir_rows.push_back(mk(CMD_ALLOC, 32'd9, 0, 0, 0, ST_OK));
		dir_rows.push_back(mk(CMD_ALLOC, 32'd28, 0, 0, 0, ST_OK));
		dir_rows.push_back(mk(CMD_FREE, 0, 32'h0000_0001, 1, 0, ST_RANGE));
		foreach (dir_rows[i])
			send_cmd(dir_rows[i].cmd, dir_rows[i].sz, dir_rows[i].addr,
				dir_rows[i].fixed, dir_rows[i].want);

		random_phase(150, 0);
		write_base(32'hFFFF_F000); // data addresses wrap past the top
		random_phase(100, 53);
		write_base(32'h0000_0000);
		random_phase(100, 25);
		// fill the table to its limit with small blocks
		idle_pct = 0;
		repeat (300) send_cmd(CMD_ALLOC, $urandom_range(1, 16), 0, 0, '0);
		write_base(32'hA5A5_5A58);
		random_phase(100, 53);
		write_base(BASE_RESET);
		random_phase(80, 0);
		drain();

		$display("%0d commands sent, %0d results checked, %0d splits, %0d unsplit on full table",
			n_beats, n_checked, n_split, n_full);
		if (n_fail == 0 && pending_res.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule

// ===== files.f =====
hdl/ffha_pkg.sv
hdl/ffha_ctrl.sv
hdl/ffha_dp.sv
hdl/first_fit_heap_allocator.sv
dv/tb_first_fit_heap_allocator.sv
